// ===== src/u8sd_pkg.sv =====
package u8sd_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned CONT_W  = 6;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_TRUNC    = 2'd2
  } status_t;

  // byte item from input register to decoder
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_buffer;
  } in_item_t;

  // decoder result toward output register
  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] code_point;
    status_t         status;
  } result_t;

endpackage

// ===== src/u8sd_in_stage.sv =====
module u8sd_in_stage
  import u8sd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_buffer,
  input  logic              advance,
  output logic              item_valid,
  output in_item_t          item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.data_byte     <= in_data_byte;
      item_r.end_of_buffer <= in_end_of_buffer;
    end
  end

endmodule

// ===== src/u8sd_core.sv =====
module u8sd_core
  import u8sd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     advance,
  input  in_item_t item,
  output result_t  result
);

  logic [CP_W-1:0]  partial_r;
  logic [CP_W-1:0]  partial_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [BYTE_W-1:0] c;
  logic [CP_W-1:0]  shifted;
  logic             is_lead;

  assign c       = item.data_byte;
  assign shifted = {partial_r[CP_W-CONT_W-1:0], c[CONT_W-1:0]};

  always_comb begin
    partial_nxt       = partial_r;
    cnt_nxt           = cnt_r;
    is_lead           = 1'b0;
    result.emit       = 1'b0;
    result.code_point = '0;
    result.status     = ST_OK;
    if (cnt_r == '0) begin
      priority if (c[7] == 1'b0) begin
        result.emit       = 1'b1;
        result.code_point = {{(CP_W-BYTE_W){1'b0}}, c};
      end else if (c[7:5] == 3'b110) begin
        is_lead     = 1'b1;
        partial_nxt = {{(CP_W-5){1'b0}}, c[4:0]};
        cnt_nxt     = CNT_W'(1);
      end else if (c[7:4] == 4'b1110) begin
        is_lead     = 1'b1;
        partial_nxt = {{(CP_W-4){1'b0}}, c[3:0]};
        cnt_nxt     = CNT_W'(2);
      end else if (c[7:3] == 5'b11110) begin
        is_lead     = 1'b1;
        partial_nxt = {{(CP_W-3){1'b0}}, c[2:0]};
        cnt_nxt     = CNT_W'(3);
      end else begin
        result.emit   = 1'b1;
        result.status = ST_BAD_LEAD;
      end
      if (is_lead && item.end_of_buffer) begin
        partial_nxt   = '0;
        cnt_nxt       = '0;
        result.emit   = 1'b1;
        result.status = ST_TRUNC;
      end
    end else begin
      cnt_nxt = cnt_r - CNT_W'(1);
      priority if (cnt_nxt == '0) begin
        partial_nxt       = '0;
        result.emit       = 1'b1;
        result.code_point = shifted;
      end else if (item.end_of_buffer) begin
        partial_nxt   = '0;
        cnt_nxt       = '0;
        result.emit   = 1'b1;
        result.status = ST_TRUNC;
      end else begin
        partial_nxt = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      cnt_r     <= '0;
    end else if (advance) begin
      partial_r <= partial_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  a_eob_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.end_of_buffer |=> cnt_r == '0)
    else $error("sequence state survives end of buffer");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    result.emit && result.status != ST_OK |-> result.code_point == '0)
    else $error("error result with nonzero code point");

  a_mid_silent: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cnt_r != '0 && !result.emit |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("continuation count did not step down");

  a_lead_count: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cnt_r == '0 && c[7:4] == 4'b1110 && !item.end_of_buffer |=> cnt_r == CNT_W'(2))
    else $error("three-byte lead did not expect two continuation bytes");

endmodule

// ===== src/u8sd_out_stage.sv =====
module u8sd_out_stage
  import u8sd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  result_t         result,
  output logic            space,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_code_point,
  output logic [1:0]      out_status
);

  logic            valid_r;
  logic            valid_nxt;
  logic [CP_W-1:0] cp_r;
  status_t         status_r;

  assign space          = !valid_r || out_ready;
  assign out_valid      = valid_r;
  assign out_code_point = cp_r;
  assign out_status     = status_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r     <= result.code_point;
      status_r <= result.status;
    end
  end

endmodule

// ===== src/utf8_stream_decoder_top.sv =====
// Each item passes the input register, then its result the output register.
// Throughput: one byte per cycle while out_ready stays high; the decode
//   state (partial value, continuation count) is registered and updates on each advance.
// Bytes that only start or extend a sequence give no result.
// Reset: synchronous, active low; clears both stages and the decode state.
module utf8_stream_decoder_top
  import u8sd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_buffer,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CP_W-1:0]   out_code_point,
  output logic [1:0]        out_status
);

  logic     item_valid;
  in_item_t item;
  result_t  result;
  logic     space;
  logic     advance;

  assign advance = item_valid && space;

  u8sd_in_stage u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .advance          (advance),
    .item_valid       (item_valid),
    .item             (item)
  );

  u8sd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  u8sd_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (advance && result.emit),
    .result         (result),
    .space          (space),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_status     (out_status)
  );

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import u8sd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned IDLE_PCT     = 36;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    status_t         status;
  } decoded_t;

  // typed = 1: expectation given by emit/cp/status instead of the decoder model
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eob;
    logic              typed;
    logic              emit;
    logic [CP_W-1:0]   cp;
    status_t           status;
  } byte_row_t;

  localparam int unsigned NUM_ROWS = 25;

  byte_row_t byte_table [NUM_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 21'h0,  ST_OK},
    '{8'h7F, 1'b1, 1'b1, 1'b1, 21'h7F, ST_OK},
    '{8'h80, 1'b0, 1'b1, 1'b1, 21'h0,  ST_BAD_LEAD},
    '{8'hBF, 1'b0, 1'b1, 1'b1, 21'h0,  ST_BAD_LEAD},
    '{8'hF8, 1'b0, 1'b1, 1'b1, 21'h0,  ST_BAD_LEAD},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 21'h0,  ST_BAD_LEAD},
    '{8'hC2, 1'b0, 1'b1, 1'b0, 21'h0,  ST_OK},
    '{8'hA9, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'hE2, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'h82, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'hAC, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'hF0, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'h9F, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'h98, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'h80, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'hF7, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'hC3, 1'b1, 1'b1, 1'b1, 21'h0,  ST_TRUNC},
    '{8'hF4, 1'b0, 1'b1, 1'b0, 21'h0,  ST_OK},
    '{8'h8F, 1'b1, 1'b1, 1'b1, 21'h0,  ST_TRUNC},
    '{8'hE1, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'h41, 1'b0, 1'b0, 1'b0, 21'h0,  ST_OK},
    '{8'h00, 1'b1, 1'b0, 1'b0, 21'h0,  ST_OK}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_data_byte;
  logic              in_end_of_buffer;
  logic              out_valid;
  logic              out_ready;
  logic [CP_W-1:0]   out_code_point;
  logic [1:0]        out_status;

  // decoder model state
  logic [CP_W-1:0]  cp_acc;
  logic [CNT_W-1:0] cont_left;

  decoded_t    expected_cp_q [$];
  byte_row_t   cur_row;
  decoded_t    model_out;
  bit          model_has;
  decoded_t    want;

  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned fail_count;
  int unsigned ok_seen;
  int unsigned bad_lead_seen;
  int unsigned trunc_seen;

  utf8_stream_decoder_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_status       (out_status)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic eob,
                             output bit has_result, output decoded_t r);
    has_result = 1'b0;
    r = '0;
    r.status = ST_OK;
    if (cont_left == '0) begin
      if (!b[7]) begin
        has_result = 1'b1;
        r.code_point = CP_W'(b);
      end else if (b[7:5] == 3'b110) begin
        cp_acc = CP_W'(b[4:0]);
        cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_acc = CP_W'(b[3:0]);
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_acc = CP_W'(b[2:0]);
        cont_left = 2'd3;
      end else begin
        has_result = 1'b1;
        r.status = ST_BAD_LEAD;
      end
      if (cont_left != '0 && eob) begin
        cp_acc = '0;
        cont_left = '0;
        has_result = 1'b1;
        r.status = ST_TRUNC;
      end
    end else begin
      cp_acc = {cp_acc[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == '0) begin
        has_result = 1'b1;
        r.code_point = cp_acc;
        cp_acc = '0;
      end else if (eob) begin
        cp_acc = '0;
        cont_left = '0;
        has_result = 1'b1;
        r.status = ST_TRUNC;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_byte(in_data_byte, in_end_of_buffer, model_has, model_out);
        if (cur_row.typed) begin
          if (cur_row.emit)
            expected_cp_q.push_back('{cur_row.cp, cur_row.status});
        end else if (model_has) begin
          expected_cp_q.push_back(model_out);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_cp_q.size() == 0) begin
          $error("unexpected item: code_point %h status %0d", out_code_point, out_status);
          fail_count++;
        end else begin
          want = expected_cp_q.pop_front();
          if (out_code_point !== want.code_point) begin
            $error("code_point mismatch: expected %h, actual %h",
                   want.code_point, out_code_point);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
          case (want.status)
            ST_OK:       ok_seen++;
            ST_BAD_LEAD: bad_lead_seen++;
            default:     trunc_seen++;
          endcase
        end
      end
    end
  end

  // output side: random stalls, or a long counted hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready = 1'b0;
      end else begin
        out_ready = !rx_idle_en || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input byte_row_t row);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cur_row = row;
    in_data_byte = row.data;
    in_end_of_buffer = row.eob;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  function automatic logic [BYTE_W-1:0] cont_byte();
    if ($urandom_range(99) < 85)
      return {2'b10, 6'($urandom)};
    return 8'($urandom);
  endfunction

  // mostly well-formed sequences, some cut short by end of buffer, some noise
  task automatic send_sequence();
    int unsigned kind;
    int unsigned seq_len;
    int unsigned stop;
    bit          cut;
    byte_row_t   row;
    kind = $urandom_range(99);
    row = '0;
    row.status = ST_OK;
    if (kind >= 80) begin
      row.data = 8'($urandom);
      row.eob = ($urandom_range(99) < 25);
      send_byte(row);
    end else begin
      cut = (kind >= 60);
      seq_len = cut ? $urandom_range(4, 2) : $urandom_range(4, 1);
      stop = cut ? $urandom_range(seq_len - 1, 1) : seq_len;
      for (int unsigned i = 0; i < stop; i++) begin
        if (i == 0) begin
          case (seq_len)
            1:       row.data = {1'b0, 7'($urandom)};
            2:       row.data = {3'b110, 5'($urandom)};
            3:       row.data = {4'b1110, 4'($urandom)};
            default: row.data = {5'b11110, 3'($urandom)};
          endcase
        end else begin
          row.data = cont_byte();
        end
        if (i != stop - 1)
          row.eob = 1'b0;
        else
          row.eob = cut || ($urandom_range(99) < 20);
        send_byte(row);
      end
    end
  endtask

  task automatic send_random(input int unsigned n);
    int unsigned target;
    target = bytes_sent + n;
    while (bytes_sent < target)
      send_sequence();
  endtask

  task automatic drain_expected();
    in_valid = 1'b0;
    wait (expected_cp_q.size() == 0);
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_end_of_buffer = 1'b0;
    cur_row = '0;
    cp_acc = '0;
    cont_left = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    bytes_sent = 0;
    fail_count = 0;
    ok_seen = 0;
    bad_lead_seen = 0;
    trunc_seen = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_ROWS; i++)
      send_byte(byte_table[i]);
    drain_expected();

    send_random(150);

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(100);
    rx_idle_en = 1'b1;

    // output held off while input keeps streaming
    hold_req = 1'b1;
    send_random(100);
    tx_idle_en = 1'b1;
    drain_expected();

    send_random(150);

    in_valid = 1'b0;
    wait (expected_cp_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; checked %0d code points, %0d invalid leads, %0d truncations.",
             bytes_sent, ok_seen, bad_lead_seen, trunc_seen);
    $display("Phases: random gaps both sides, gap-free streaming, long output hold-off.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
